@@ rtl/sqll_pkg.sv @@
// ----------------------------------------------------------------------------
// sqll_pkg
// Shared types, token codes and the keyword table for the SQL token lexer.
// ----------------------------------------------------------------------------
package sqll_pkg;

  localparam int unsigned MaxStatementBytesDef = 65536;
  localparam int unsigned KeywordCharsDef      = 8;
  localparam int unsigned MaxResults           = 3;
  localparam int unsigned NumKeywords          = 22;

  // token kinds
  localparam logic [5:0] KIND_EOF     = 6'd0;
  localparam logic [5:0] KIND_INVALID = 6'd1;
  localparam logic [5:0] KIND_INT     = 6'd2;
  localparam logic [5:0] KIND_FLOAT   = 6'd3;
  localparam logic [5:0] KIND_STRING  = 6'd4;
  localparam logic [5:0] KIND_IDENT   = 6'd5;
  localparam logic [5:0] KIND_PLUS    = 6'd27;
  localparam logic [5:0] KIND_MINUS   = 6'd28;
  localparam logic [5:0] KIND_STAR    = 6'd29;
  localparam logic [5:0] KIND_SLASH   = 6'd30;
  localparam logic [5:0] KIND_LPAREN  = 6'd31;
  localparam logic [5:0] KIND_RPAREN  = 6'd32;
  localparam logic [5:0] KIND_COMMA   = 6'd33;
  localparam logic [5:0] KIND_SEMI    = 6'd34;
  localparam logic [5:0] KIND_DOT     = 6'd35;
  localparam logic [5:0] KIND_EQ      = 6'd36;
  localparam logic [5:0] KIND_LT      = 6'd37;
  localparam logic [5:0] KIND_LE      = 6'd38;
  localparam logic [5:0] KIND_NE      = 6'd39;
  localparam logic [5:0] KIND_GT      = 6'd40;
  localparam logic [5:0] KIND_GE      = 6'd41;

  // error kinds
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NUMBER    = 3'd1;
  localparam logic [2:0] ERR_OPEN_STR  = 3'd2;
  localparam logic [2:0] ERR_BANG      = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd4;

  // lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_NUM   = 3'd1;
  localparam logic [2:0] MODE_STR   = 3'd2;
  localparam logic [2:0] MODE_WORD  = 3'd3;
  localparam logic [2:0] MODE_HOLD  = 3'd4;
  localparam logic [2:0] MODE_LCOM  = 3'd5;
  localparam logic [2:0] MODE_BCOM  = 3'd6;
  localparam logic [2:0] MODE_BSTAR = 3'd7;

  // keyword text, first char in the top byte, zero padded
  localparam logic [63:0] KW_TXT [NumKeywords] = '{
    {"SELECT", 16'h0}, {"FROM", 32'h0}, {"WHERE", 24'h0}, {"INSERT", 16'h0},
    {"INTO", 32'h0}, {"VALUES", 16'h0}, {"CREATE", 16'h0}, {"TABLE", 24'h0},
    {"UPDATE", 16'h0}, {"SET", 40'h0}, {"DELETE", 16'h0}, {"DROP", 32'h0},
    {"AND", 40'h0}, {"OR", 48'h0}, {"NOT", 40'h0}, {"NULL", 32'h0},
    {"PRIMARY", 8'h0}, {"KEY", 40'h0}, {"INT", 40'h0}, {"INTEGER", 8'h0},
    {"VARCHAR", 8'h0}, {"FLOAT", 24'h0}
  };

  localparam logic [5:0] KW_CODE [NumKeywords] = '{
    6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
    6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] offset;
    logic [15:0] length;
  } res_t;

  // results caused by one input item
  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [1:0]            cnt;
  } bundle_t;

  function automatic res_t mk_res(logic [5:0] kind, logic [2:0] err, logic [15:0] line,
                                  logic [15:0] column, logic [15:0] offset,
                                  logic [15:0] length);
    res_t r;
    r.kind   = kind;
    r.err    = err;
    r.line   = line;
    r.column = column;
    r.offset = offset;
    r.length = length;
    return r;
  endfunction

  function automatic logic [15:0] inc_sat(logic [15:0] v, logic [15:0] cap);
    return (v < cap) ? v + 16'd1 : v;
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
  endfunction

endpackage

@@ rtl/sqll_core.sv @@
// ----------------------------------------------------------------------------
// sqll_core
// Lexer state registers and the single-pass next-state / result logic.
// ----------------------------------------------------------------------------
module sqll_core #(
  parameter int unsigned MAX_STATEMENT_BYTES = sqll_pkg::MaxStatementBytesDef,
  parameter int unsigned KEYWORD_CHARS       = sqll_pkg::KeywordCharsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              final_byte_i,
  output sqll_pkg::bundle_t bundle_o
);

  localparam int unsigned CapInt = (MAX_STATEMENT_BYTES - 1 < 65535) ?
                                   MAX_STATEMENT_BYTES - 1 : 65535;
  localparam logic [15:0] PosCap = 16'(CapInt);
  localparam logic [15:0] Cnt16Cap = 16'hFFFF;
  localparam int unsigned LenW = $clog2(KEYWORD_CHARS + 1);
  localparam int unsigned IdxW = $clog2(KEYWORD_CHARS);
  localparam logic [LenW-1:0] KwFull = LenW'(KEYWORD_CHARS);

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic [KEYWORD_CHARS-1:0][7:0] wbuf_q, wbuf_d;
  logic [LenW-1:0] wlen_q, wlen_d;
  logic        wlong_q, wlong_d;
  logic        dot_q, dot_d;
  logic        esc_q, esc_d;
  logic        drop_q, drop_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic [15:0] spos_q, spos_d;
  logic [15:0] scol_q, scol_d;
  logic [15:0] sline_q, sline_d;

  function automatic logic [5:0] kw_kind(logic [KEYWORD_CHARS-1:0][7:0] b, logic tl);
    logic [5:0]  k;
    logic        same;
    logic [63:0] sh;
    k = sqll_pkg::KIND_IDENT;
    for (int j = sqll_pkg::NumKeywords - 1; j >= 0; j--) begin
      same = 1'b1;
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        sh = sqll_pkg::KW_TXT[j] << (8 * i);
        if (b[i] != sh[63:56]) same = 1'b0;
      end
      if (same) k = sqll_pkg::KW_CODE[j];
    end
    if (tl) k = sqll_pkg::KIND_IDENT;
    return k;
  endfunction

  function automatic logic [15:0] span(logic [15:0] e, logic [15:0] s);
    return (e >= s) ? e - s : 16'd0;
  endfunction

  logic [5:0] kind_old;
  assign kind_old = kw_kind(wbuf_q, wlong_q);

  always_comb begin
    logic [7:0]  ch;
    logic [1:0]  n;
    logic        dobeg;
    logic [15:0] np, ncol, nln;
    ch = text_byte_i;
    n  = 2'd0;
    dobeg = 1'b0;
    bundle_o = '0;
    mode_d = mode_q; held_d = held_q; wbuf_d = wbuf_q; wlen_d = wlen_q;
    wlong_d = wlong_q; dot_d = dot_q; esc_d = esc_q; drop_d = drop_q;
    spos_d = spos_q; scol_d = scol_q; sline_d = sline_q;

    if (!drop_q) begin
      unique case (mode_q)
        sqll_pkg::MODE_NUM: begin
          if (sqll_pkg::is_digit(ch)) begin
          end else if (ch == ".") begin
            if (dot_q) begin
              bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_INVALID,
                sqll_pkg::ERR_NUMBER, line_q, col_q, spos_q, 16'd0);
              n = n + 2'd1; drop_d = 1'b1; mode_d = sqll_pkg::MODE_IDLE;
            end else dot_d = 1'b1;
          end else begin
            bundle_o.res[n] = sqll_pkg::mk_res(dot_q ? sqll_pkg::KIND_FLOAT :
              sqll_pkg::KIND_INT, sqll_pkg::ERR_NONE, sline_q, scol_q, spos_q,
              span(pos_q, spos_q));
            n = n + 2'd1; mode_d = sqll_pkg::MODE_IDLE; dobeg = 1'b1;
          end
        end
        sqll_pkg::MODE_WORD: begin
          if (sqll_pkg::is_alpha(ch) || sqll_pkg::is_digit(ch) || ch == "_") begin
            if (wlen_q < KwFull) begin
              wbuf_d[wlen_q[IdxW-1:0]] = sqll_pkg::to_upper(ch);
              wlen_d = wlen_q + LenW'(1);
            end else wlong_d = 1'b1;
          end else begin
            bundle_o.res[n] = sqll_pkg::mk_res(kind_old, sqll_pkg::ERR_NONE, sline_q,
              scol_q, spos_q, span(pos_q, spos_q));
            n = n + 2'd1; mode_d = sqll_pkg::MODE_IDLE; dobeg = 1'b1;
          end
        end
        sqll_pkg::MODE_STR: begin
          if (esc_q) esc_d = 1'b0;
          else if (ch == "\\") esc_d = 1'b1;
          else if (ch == "'") begin
            bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_STRING, sqll_pkg::ERR_NONE,
              sline_q, scol_q, spos_q, span(pos_q, spos_q));
            n = n + 2'd1; mode_d = sqll_pkg::MODE_IDLE;
          end
        end
        sqll_pkg::MODE_HOLD: begin
          if (held_q == "-" && ch == "-") mode_d = sqll_pkg::MODE_LCOM;
          else if (held_q == "/" && ch == "*") mode_d = sqll_pkg::MODE_BCOM;
          else if ((held_q == "<" && (ch == "=" || ch == ">")) ||
                   (held_q == ">" && ch == "=") || (held_q == "!" && ch == "=")) begin
            bundle_o.res[n] = sqll_pkg::mk_res(
              (held_q == ">") ? sqll_pkg::KIND_GE :
              (held_q == "!" || ch == ">") ? sqll_pkg::KIND_NE : sqll_pkg::KIND_LE,
              sqll_pkg::ERR_NONE, sline_q, scol_q, spos_q,
              span(sqll_pkg::inc_sat(pos_q, PosCap), spos_q));
            n = n + 2'd1; mode_d = sqll_pkg::MODE_IDLE;
          end else begin
            mode_d = sqll_pkg::MODE_IDLE;
            if (held_q == "-" || held_q == "/" || held_q == "<" || held_q == ">") begin
              bundle_o.res[n] = sqll_pkg::mk_res(
                (held_q == "-") ? sqll_pkg::KIND_MINUS :
                (held_q == "/") ? sqll_pkg::KIND_SLASH :
                (held_q == "<") ? sqll_pkg::KIND_LT : sqll_pkg::KIND_GT,
                sqll_pkg::ERR_NONE, sline_q, scol_q, spos_q, 16'd1);
              n = n + 2'd1; dobeg = 1'b1;
            end else begin
              bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_INVALID,
                sqll_pkg::ERR_BANG, line_q, col_q, spos_q, 16'd0);
              n = n + 2'd1; drop_d = 1'b1;
            end
          end
        end
        sqll_pkg::MODE_LCOM: if (ch == 8'h0A) mode_d = sqll_pkg::MODE_IDLE;
        sqll_pkg::MODE_BCOM: if (ch == "*") mode_d = sqll_pkg::MODE_BSTAR;
        sqll_pkg::MODE_BSTAR: begin
          if (ch == "/") mode_d = sqll_pkg::MODE_IDLE;
          else if (ch != "*") mode_d = sqll_pkg::MODE_BCOM;
        end
        default: dobeg = 1'b1;
      endcase

      // start of a new token
      if (dobeg && !(ch == " " || ch == 8'h09 || ch == 8'h0D || ch == 8'h0A)) begin
        spos_d = pos_q; scol_d = col_q; sline_d = line_q;
        if (sqll_pkg::is_digit(ch)) begin
          mode_d = sqll_pkg::MODE_NUM; dot_d = 1'b0;
        end else if (ch == "'") begin
          mode_d = sqll_pkg::MODE_STR; esc_d = 1'b0;
          spos_d = sqll_pkg::inc_sat(pos_q, PosCap);
        end else if (sqll_pkg::is_alpha(ch) || ch == "_") begin
          mode_d = sqll_pkg::MODE_WORD;
          wbuf_d = '0;
          wbuf_d[0] = sqll_pkg::to_upper(ch);
          wlen_d = LenW'(1);
          wlong_d = 1'b0;
        end else if (ch == "-" || ch == "/" || ch == "<" || ch == ">" || ch == "!") begin
          mode_d = sqll_pkg::MODE_HOLD; held_d = ch;
        end else if (ch == "+" || ch == "*" || ch == "(" || ch == ")" || ch == "," ||
                     ch == ";" || ch == "." || ch == "=") begin
          bundle_o.res[n] = sqll_pkg::mk_res(
            (ch == "+") ? sqll_pkg::KIND_PLUS :
            (ch == "*") ? sqll_pkg::KIND_STAR :
            (ch == "(") ? sqll_pkg::KIND_LPAREN :
            (ch == ")") ? sqll_pkg::KIND_RPAREN :
            (ch == ",") ? sqll_pkg::KIND_COMMA :
            (ch == ";") ? sqll_pkg::KIND_SEMI :
            (ch == ".") ? sqll_pkg::KIND_DOT : sqll_pkg::KIND_EQ,
            sqll_pkg::ERR_NONE, line_q, col_q, pos_q, 16'd1);
          n = n + 2'd1;
        end else begin
          bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_INVALID,
            sqll_pkg::ERR_BAD_CHAR, line_q, sqll_pkg::inc_sat(col_q, Cnt16Cap),
            pos_q, 16'd0);
          n = n + 2'd1; drop_d = 1'b1; mode_d = sqll_pkg::MODE_IDLE;
        end
      end
    end

    np = sqll_pkg::inc_sat(pos_q, PosCap);
    if (ch == 8'h0A) begin
      nln = sqll_pkg::inc_sat(line_q, Cnt16Cap); ncol = 16'd1;
    end else begin
      nln = line_q; ncol = sqll_pkg::inc_sat(col_q, Cnt16Cap);
    end
    pos_d = np; line_d = nln; col_d = ncol;

    if (final_byte_i) begin
      if (!drop_d) begin
        if (mode_d == sqll_pkg::MODE_NUM) begin
          bundle_o.res[n] = sqll_pkg::mk_res(dot_d ? sqll_pkg::KIND_FLOAT :
            sqll_pkg::KIND_INT, sqll_pkg::ERR_NONE, sline_d, scol_d, spos_d,
            span(np, spos_d));
          n = n + 2'd1;
        end else if (mode_d == sqll_pkg::MODE_WORD) begin
          bundle_o.res[n] = sqll_pkg::mk_res(kw_kind(wbuf_d, wlong_d),
            sqll_pkg::ERR_NONE, sline_d, scol_d, spos_d, span(np, spos_d));
          n = n + 2'd1;
        end else if (mode_d == sqll_pkg::MODE_STR) begin
          bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_INVALID,
            sqll_pkg::ERR_OPEN_STR, nln, ncol, spos_d, 16'd0);
          n = n + 2'd1;
        end else if (mode_d == sqll_pkg::MODE_HOLD) begin
          if (held_d == "!") begin
            bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_INVALID,
              sqll_pkg::ERR_BANG, nln, ncol, spos_d, 16'd0);
          end else begin
            bundle_o.res[n] = sqll_pkg::mk_res(
              (held_d == "-") ? sqll_pkg::KIND_MINUS :
              (held_d == "/") ? sqll_pkg::KIND_SLASH :
              (held_d == "<") ? sqll_pkg::KIND_LT : sqll_pkg::KIND_GT,
              sqll_pkg::ERR_NONE, sline_d, scol_d, spos_d, 16'd1);
          end
          n = n + 2'd1;
        end
      end
      // at most three tokens per item: EOF is dropped when all slots are taken
      if (n != 2'd3) begin
        bundle_o.res[n] = sqll_pkg::mk_res(sqll_pkg::KIND_EOF, sqll_pkg::ERR_NONE,
          nln, ncol, np, 16'd0);
        n = n + 2'd1;
      end
      // statement done: back to reset values
      mode_d = sqll_pkg::MODE_IDLE; held_d = '0; wbuf_d = '0; wlen_d = '0;
      wlong_d = 1'b0; dot_d = 1'b0; esc_d = 1'b0; drop_d = 1'b0;
      pos_d = '0; line_d = 16'd1; col_d = 16'd1;
      spos_d = '0; scol_d = 16'd1; sline_d = 16'd1;
    end
    bundle_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sqll_pkg::MODE_IDLE; held_q <= '0; wbuf_q <= '0; wlen_q <= '0;
      wlong_q <= 1'b0; dot_q <= 1'b0; esc_q <= 1'b0; drop_q <= 1'b0;
      pos_q <= '0; line_q <= 16'd1; col_q <= 16'd1;
      spos_q <= '0; scol_q <= 16'd1; sline_q <= 16'd1;
    end else if (accept_i) begin
      mode_q <= mode_d; held_q <= held_d; wbuf_q <= wbuf_d; wlen_q <= wlen_d;
      wlong_q <= wlong_d; dot_q <= dot_d; esc_q <= esc_d; drop_q <= drop_d;
      pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
      spos_q <= spos_d; scol_q <= scol_d; sline_q <= sline_d;
    end
  end

endmodule

@@ rtl/sqll_outbuf.sv @@
// ----------------------------------------------------------------------------
// sqll_outbuf
// Result register: one item's tokens, sent one a cycle while tready is high.
// ----------------------------------------------------------------------------
module sqll_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sqll_pkg::bundle_t bundle_i,
  output logic              room_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output sqll_pkg::res_t    m_res_o,
  output logic              m_tlast_o
);

  sqll_pkg::bundle_t buf_q;
  logic [1:0]        cnt_q, idx_q;

  assign m_tvalid_o = cnt_q != 2'd0;
  assign m_tlast_o  = idx_q == cnt_q - 2'd1;
  assign m_res_o    = buf_q.res[idx_q];
  // next item may enter when empty or when the last held token leaves this cycle
  assign room_o     = !m_tvalid_o || (m_tlast_o && m_tready_i);

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (m_tvalid_o && m_tready_i) begin
      if (m_tlast_o) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else idx_q <= idx_q + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> idx_q < cnt_q) else $error("token index past count");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && !m_tlast_o) |=>
      (m_tvalid_o && idx_q == $past(idx_q) + 2'd1)) else $error("token skipped");

  a_empty_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && bundle_i.cnt == 2'd0) |=> !m_tvalid_o) else $error("phantom token");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |-> !load_i) else $error("pending token overwritten");

endmodule

@@ rtl/sql_lexer_token_stream_top.sv @@
// ----------------------------------------------------------------------------
// sql_lexer_token_stream_top
// SQL lexer: one text byte per item in, typed tokens with position out.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the result register has room. Each byte is
// lexed in a single pass from the lexer state into a result register holding
// the zero to three tokens it causes; those leave one per clock while the sink
// is ready, starting the cycle after the byte is taken, and the next byte is
// taken in the cycle the last of them is taken. With a ready sink, bytes that
// cause at most one token therefore run at one per cycle; a byte with two or
// three tokens holds off the next byte until its last token is taken. The last
// byte of a statement (tlast) adds an EOF token unless it already caused three.
module sql_lexer_token_stream_top #(
  parameter int unsigned MAX_STATEMENT_BYTES = sqll_pkg::MaxStatementBytesDef,
  parameter int unsigned KEYWORD_CHARS       = sqll_pkg::KeywordCharsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] text_byte
  input  logic        s_axis_tlast_i,  // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] token_kind, [8:6] error_kind, [24:9] token_line, [40:25] token_column,
  // [56:41] token_offset, [72:57] token_length, [79:73] zero
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o   // run_last
);

  sqll_pkg::bundle_t bundle;
  sqll_pkg::res_t    res;
  logic              room, accept;

  assign s_axis_tready_o = room;
  assign accept = s_axis_tvalid_i && room;

  sqll_core #(
    .MAX_STATEMENT_BYTES(MAX_STATEMENT_BYTES),
    .KEYWORD_CHARS      (KEYWORD_CHARS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (s_axis_tdata_i),
    .final_byte_i(s_axis_tlast_i),
    .bundle_o    (bundle)
  );

  sqll_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .bundle_i  (bundle),
    .room_o    (room),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_res_o   (res),
    .m_tlast_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, res.length, res.offset, res.column, res.line,
                           res.err, res.kind};

endmodule
